// ===== rtl/hps_pkg.sv =====
// ----------------------------------------------------------------------------
// hps_pkg
// Shared types, constants and arithmetic steps of the hillshade pixel stream.
// ----------------------------------------------------------------------------
package hps_pkg;

   localparam int PIX_W      = 8;
   localparam int COL_W      = 10;
   localparam int ROW_W      = 12;
   localparam int CFG_WID_W  = 11;
   localparam int CFG_HGT_W  = 13;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 13;

   localparam logic [CFG_WID_W-1:0] WIDTH_RESET  = 11'd1024;
   localparam logic [CFG_HGT_W-1:0] HEIGHT_RESET = 13'd1024;

   localparam logic [CSR_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

   // job slots of one queued word
   localparam int JOB_MID  = 0;   // pixel of the row above
   localparam int JOB_PREV = 1;   // previous pixel of the last row
   localparam int JOB_END  = 2;   // bottom-right pixel
   localparam int NUM_JOBS = 3;

   localparam int QUEUE_DEPTH = 4;

   // arithmetic
   localparam int SQRT_STEPS = 25;
   localparam int DIV_STEPS  = 18;
   localparam logic [19:0] LIGHT_SCALE = 20'd840966;
   localparam logic [14:0] NUM_BIAS    = 15'd1792;
   localparam logic [17:0] Z_SQUARED   = 18'd16384;
   localparam logic [17:0] LAMBERT_ONE = 18'd65536;
   localparam logic [11:0] DIFFUSE_K   = 12'd2805;
   localparam logic [12:0] AMBIENT_K   = 13'd1785;
   localparam logic [12:0] HEIGHT_K    = 13'd9;
   localparam logic [12:0] ACC_CAP     = 13'd5100;
   localparam logic [15:0] DIV5_MAGIC  = 16'd52429;

   typedef struct packed {
      logic [COL_W-1:0] col;
      logic [ROW_W-1:0] row;
      logic             last;
      logic             eof;
   } tag_type;

   typedef struct packed {
      logic [PIX_W-1:0] center;
      logic [PIX_W-1:0] left;
      logic [PIX_W-1:0] right;
      logic [PIX_W-1:0] up;
      logic [PIX_W-1:0] down;
      tag_type          tag;
   } job_type;

   typedef struct packed {
      logic [NUM_JOBS-1:0] jobs;
      logic [PIX_W-1:0]    pix;
      logic [PIX_W-1:0]    prev_in;
      logic [PIX_W-1:0]    left_b;
      logic [PIX_W-1:0]    mid_c;
      logic [PIX_W-1:0]    mid_l;
      logic [PIX_W-1:0]    mid_r;
      logic [PIX_W-1:0]    up;
      logic [PIX_W-1:0]    prev_mid;
      logic [COL_W-1:0]    col;
      logic [COL_W-1:0]    col_m1;
      logic [ROW_W-1:0]    row_a;
      logic [ROW_W-1:0]    row_b;
   } rec_type;

   typedef struct packed {
      logic [26:0] rem;
      logic [24:0] root;
   } sqrt_step_type;

   typedef struct packed {
      logic [24:0] rem;
      logic        qbit;
   } div_step_type;

   // one step of a restoring square root, two radicand bits in
   function automatic sqrt_step_type sqrt_step(input logic [26:0] rem,
                                               input logic [24:0] root,
                                               input logic [1:0]  pair);
      logic [28:0]   cur;
      logic [28:0]   trial;
      sqrt_step_type res;
      cur   = {rem, pair};
      trial = {2'b00, root, 2'b01};
      if (cur >= trial) begin
         res.rem  = 27'(cur - trial);
         res.root = {root[23:0], 1'b1};
      end else begin
         res.rem  = 27'(cur);
         res.root = {root[23:0], 1'b0};
      end
      return res;
   endfunction

   // one step of a restoring division, one dividend bit in
   function automatic div_step_type div_step(input logic [24:0] rem,
                                             input logic [24:0] dvs,
                                             input logic        nbit);
      logic [25:0]  cur;
      div_step_type res;
      cur = {rem, nbit};
      if (cur >= {1'b0, dvs}) begin
         res.rem  = 25'(cur - {1'b0, dvs});
         res.qbit = 1'b1;
      end else begin
         res.rem  = 25'(cur);
         res.qbit = 1'b0;
      end
      return res;
   endfunction

endpackage

// ===== rtl/hillshade_pixel_stream.sv =====
// ----------------------------------------------------------------------------
// hillshade_pixel_stream
// Lambert hillshade of a raster-order stream of 8-bit height samples.
// ----------------------------------------------------------------------------
// Input words (req_) carry one height sample each, in raster order; a word is
// taken on a clock edge with req_valid high and req_stall low. Result words
// (rsp_) carry the shade of one pixel with its column and row; the receiver
// holds rsp_stall high to pause them. Pixels of row y-1 come out while row y
// goes in; on the last row each sample after the first gives two results,
// and the final sample three. frame_width and frame_height are written over
// the csr_ port (always ready) while the block is idle; a write restarts the
// frame. Sizes below two give no output.
// Throughput: one sample per cycle while req_stall is low, set by the front
// end's single row-store port pair; on the last row it is set by the one
// shading pipeline taking a job per cycle while the receiver does not stall.
// The pipeline has 3 gradient stages, 25 root stages, 18 division stages and
// 3 output stages. A stalled receiver freezes the pipeline; the 4-word queue
// then fills and req_stall rises. Reset clears the counters and sets both
// sizes to 1024; row stores are not cleared.
// ----------------------------------------------------------------------------
module hillshade_pixel_stream import hps_pkg::*; #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 4096
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [PIX_W-1:0]      req_height_sample,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [PIX_W-1:0]      rsp_shade,
   output logic [COL_W-1:0]      rsp_column,
   output logic [ROW_W-1:0]      rsp_row,
   output logic                  rsp_last_of_run,
   output logic                  rsp_end_of_frame,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   logic    push, pop, not_empty, full, adv, job_valid;
   rec_type push_rec, head;
   job_type job;
   tag_type tag;

   assign req_stall = full;
   assign csr_ready = 1'b1;

   hps_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_height_sample (req_height_sample),
      .full              (full),
      .csr_valid         (csr_valid),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .push              (push),
      .rec               (push_rec)
   );

   hps_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_rec  (push_rec),
      .pop       (pop),
      .head      (head),
      .not_empty (not_empty),
      .full      (full)
   );

   hps_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .not_empty (not_empty),
      .adv       (adv),
      .pop       (pop),
      .job_valid (job_valid),
      .job       (job)
   );

   hps_shade u_shade (
      .clock     (clock),
      .reset     (reset),
      .job_valid (job_valid),
      .job       (job),
      .rsp_stall (rsp_stall),
      .adv       (adv),
      .rsp_valid (rsp_valid),
      .rsp_shade (rsp_shade),
      .rsp_tag   (tag)
   );

   assign rsp_column       = tag.col;
   assign rsp_row          = tag.row;
   assign rsp_last_of_run  = tag.last;
   assign rsp_end_of_frame = tag.eof;

endmodule

// ===== rtl/hps_front.sv =====
// ----------------------------------------------------------------------------
// hps_front
// Raster counters, row stores and neighbour window; builds one queue word
// per accepted sample that causes any shading job, holding every such job.
// ----------------------------------------------------------------------------
module hps_front import hps_pkg::*; #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 4096
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic [PIX_W-1:0]      req_height_sample,
   input  logic                  full,
   input  logic                  csr_valid,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   output logic                  push,
   output rec_type               rec
);

   localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
   localparam int EW = $clog2(MAX_WIDTH + 1);
   localparam int EH = $clog2(MAX_HEIGHT + 1);

   logic [CFG_WID_W-1:0] width_ff, width_in;
   logic [CFG_HGT_W-1:0] height_ff, height_in;
   logic [CW-1:0]        c_ff, c_in;
   logic [RW-1:0]        r_ff, r_in;
   logic                 wrap_ff, wrap_in;
   logic [PIX_W-1:0]     mid_c_ff, mid_c_in;
   logic [PIX_W-1:0]     first_px_ff, first_px_in;
   logic [PIX_W-1:0]     second_px_ff, second_px_in;
   logic [PIX_W-1:0]     first_mid_ff, first_mid_in;
   logic [PIX_W-1:0]     prev_in_ff, prev_in_in;
   logic [PIX_W-1:0]     prev2_ff, prev2_in;
   logic [PIX_W-1:0]     prev_mid_ff, prev_mid_in;
   logic [PIX_W-1:0]     newer_q_ff, older_q_ff;

   logic [PIX_W-1:0] newer_mem [0:MAX_WIDTH-1];
   logic [PIX_W-1:0] older_mem [0:MAX_WIDTH-1];

   logic [EW-1:0]    eff_w;
   logic [EH-1:0]    eff_h;
   logic             active, step, cfg_hit;
   logic             c_last, row_last, c_ge1, c_ge2, r_ge1, r_ge2;
   logic [PIX_W-1:0] pix, mid_c, mid_r_raw, up_raw, mid_r, mid_l, up, left_b;

   assign eff_w  = (32'(width_ff) > MAX_WIDTH) ? EW'(MAX_WIDTH) : EW'(width_ff);
   assign eff_h  = (32'(height_ff) > MAX_HEIGHT) ? EH'(MAX_HEIGHT) : EH'(height_ff);
   assign active = (eff_w >= EW'(2)) && (eff_h >= EH'(2));
   assign step   = req_valid && !full && active;
   assign cfg_hit = csr_valid &&
                    (csr_index == REG_FRAME_WIDTH || csr_index == REG_FRAME_HEIGHT);

   assign c_last   = (EW'(c_ff) + EW'(1)) == eff_w;
   assign row_last = (EH'(r_ff) + EH'(1)) == eff_h;
   assign c_ge1    = c_ff != '0;
   assign c_ge2    = 32'(c_ff) >= 2;
   assign r_ge1    = r_ff != '0;
   assign r_ge2    = 32'(r_ff) >= 2;

   // at the start of a row the window comes from words captured on the row before
   assign pix       = req_height_sample;
   assign mid_c     = wrap_ff ? first_px_ff  : mid_c_ff;
   assign mid_r_raw = wrap_ff ? second_px_ff : newer_q_ff;
   assign up_raw    = wrap_ff ? first_mid_ff : older_q_ff;
   assign mid_r     = c_last ? mid_c : mid_r_raw;
   assign mid_l     = c_ge1 ? prev_mid_ff : mid_c;
   assign up        = r_ge2 ? up_raw : mid_c;
   assign left_b    = c_ge2 ? prev2_ff : prev_in_ff;

   always_comb begin
      rec.jobs[JOB_MID]  = r_ge1;
      rec.jobs[JOB_PREV] = row_last && c_ge1;
      rec.jobs[JOB_END]  = row_last && c_last;
      rec.pix      = pix;
      rec.prev_in  = prev_in_ff;
      rec.left_b   = left_b;
      rec.mid_c    = mid_c;
      rec.mid_l    = mid_l;
      rec.mid_r    = mid_r;
      rec.up       = up;
      rec.prev_mid = prev_mid_ff;
      rec.col      = COL_W'(c_ff);
      rec.col_m1   = COL_W'(c_ff - CW'(1));
      rec.row_a    = ROW_W'(r_ff - RW'(1));
      rec.row_b    = ROW_W'(r_ff);
   end

   assign push = step && (rec.jobs != '0);

   always_comb begin
      width_in     = width_ff;
      height_in    = height_ff;
      c_in         = c_ff;
      r_in         = r_ff;
      wrap_in      = wrap_ff;
      mid_c_in     = mid_c_ff;
      first_px_in  = first_px_ff;
      second_px_in = second_px_ff;
      first_mid_in = first_mid_ff;
      prev_in_in   = prev_in_ff;
      prev2_in     = prev2_ff;
      prev_mid_in  = prev_mid_ff;
      priority if (cfg_hit) begin
         if (csr_index == REG_FRAME_WIDTH) begin
            width_in = CFG_WID_W'(csr_data);
         end else begin
            height_in = csr_data;
         end
         c_in        = '0;
         r_in        = '0;
         wrap_in     = 1'b1;
         prev_in_in  = '0;
         prev_mid_in = '0;
      end else if (step) begin
         wrap_in     = c_last;
         mid_c_in    = mid_r_raw;
         prev2_in    = prev_in_ff;
         prev_in_in  = pix;
         prev_mid_in = mid_c;
         if (c_ff == '0) begin
            first_px_in  = pix;
            first_mid_in = mid_c;
         end
         if (c_ff == CW'(1)) begin
            second_px_in = pix;
         end
         if (c_last) begin
            c_in = '0;
            r_in = row_last ? '0 : r_ff + RW'(1);
         end else begin
            c_in = c_ff + CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff    <= WIDTH_RESET;
         height_ff   <= HEIGHT_RESET;
         c_ff        <= '0;
         r_ff        <= '0;
         wrap_ff     <= 1'b1;
         prev_in_ff  <= '0;
         prev_mid_ff <= '0;
      end else begin
         width_ff    <= width_in;
         height_ff   <= height_in;
         c_ff        <= c_in;
         r_ff        <= r_in;
         wrap_ff     <= wrap_in;
         prev_in_ff  <= prev_in_in;
         prev_mid_ff <= prev_mid_in;
      end
   end

   always_ff @(posedge clock) begin
      mid_c_ff     <= mid_c_in;
      first_px_ff  <= first_px_in;
      second_px_ff <= second_px_in;
      first_mid_ff <= first_mid_in;
      prev2_ff     <= prev2_in;
   end

   // row stores: read ahead (newer two columns, older one column) so the window is ready for the next word
   always_ff @(posedge clock) begin
      if (step) begin
         newer_mem[c_ff] <= pix;
         older_mem[c_ff] <= mid_c;
         newer_q_ff      <= newer_mem[CW'(32'(c_ff) + 2)];
         older_q_ff      <= older_mem[CW'(32'(c_ff) + 1)];
      end
   end

endmodule

// ===== rtl/hps_queue.sv =====
// ----------------------------------------------------------------------------
// hps_queue
// Short FIFO of job words between the front and the shading back end.
// ----------------------------------------------------------------------------
module hps_queue import hps_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  rec_type push_rec,
   input  logic    pop,
   output rec_type head,
   output logic    not_empty,
   output logic    full
);

   localparam int PW = $clog2(QUEUE_DEPTH);
   localparam int NW = $clog2(QUEUE_DEPTH + 1);

   rec_type        slot_ff [0:QUEUE_DEPTH-1];
   logic [PW-1:0]  wr_ff, wr_in, rd_ff, rd_in;
   logic [NW-1:0]  cnt_ff, cnt_in;

   assign head      = slot_ff[rd_ff];
   assign not_empty = cnt_ff != '0;
   assign full      = cnt_ff == NW'(QUEUE_DEPTH);

   always_comb begin
      wr_in  = push ? PW'(32'(wr_ff) + 1) : wr_ff;
      rd_in  = pop  ? PW'(32'(rd_ff) + 1) : rd_ff;
      cnt_in = cnt_ff + NW'(push) - NW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_rec;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && full))
      else $error("word pushed into full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !(pop && !not_empty))
      else $error("word popped from empty queue");

   a_count_tracks: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (cnt_ff == $past(cnt_ff) + NW'(1)))
      else $error("queue fill count lost a word");

endmodule

// ===== rtl/hps_seq.sv =====
// ----------------------------------------------------------------------------
// hps_seq
// Takes the head word of the queue apart into up to three shading jobs,
// one per cycle while adv is high, in raster order of the results.
// ----------------------------------------------------------------------------
module hps_seq import hps_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  rec_type head,
   input  logic    not_empty,
   input  logic    adv,
   output logic    pop,
   output logic    job_valid,
   output job_type job
);

   logic [NUM_JOBS-1:0] done_ff, done_in;
   logic [NUM_JOBS-1:0] remaining, pick, rest;

   assign remaining = head.jobs & ~done_ff;

   always_comb begin
      priority if (remaining[JOB_MID]) begin
         pick = NUM_JOBS'(1) << JOB_MID;
      end else if (remaining[JOB_PREV]) begin
         pick = NUM_JOBS'(1) << JOB_PREV;
      end else begin
         pick = NUM_JOBS'(1) << JOB_END;
      end
   end

   assign rest      = remaining & ~pick;
   assign job_valid = not_empty && adv;
   assign pop       = job_valid && (rest == '0);

   always_comb begin
      job.tag.last = rest == '0;
      priority if (pick[JOB_MID]) begin
         job.center  = head.mid_c;
         job.left    = head.mid_l;
         job.right   = head.mid_r;
         job.up      = head.up;
         job.down    = head.pix;
         job.tag.col = head.col;
         job.tag.row = head.row_a;
         job.tag.eof = 1'b0;
      end else if (pick[JOB_PREV]) begin
         job.center  = head.prev_in;
         job.left    = head.left_b;
         job.right   = head.pix;
         job.up      = head.prev_mid;
         job.down    = head.prev_in;
         job.tag.col = head.col_m1;
         job.tag.row = head.row_b;
         job.tag.eof = 1'b0;
      end else begin
         job.center  = head.pix;
         job.left    = head.prev_in;
         job.right   = head.pix;
         job.up      = head.mid_c;
         job.down    = head.pix;
         job.tag.col = head.col;
         job.tag.row = head.row_b;
         job.tag.eof = 1'b1;
      end
   end

   always_comb begin
      done_in = done_ff;
      if (job_valid) begin
         done_in = (rest == '0) ? '0 : (done_ff | pick);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff <= '0;
      end else begin
         done_ff <= done_in;
      end
   end

endmodule

// ===== rtl/hps_shade.sv =====
// ----------------------------------------------------------------------------
// hps_shade
// Shading pipeline: gradient, normal length by bit-pair square root,
// Lambert term by restoring division, then ambient mix and scaling.
// All stages move together and hold while the result register is stalled.
// ----------------------------------------------------------------------------
module hps_shade import hps_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             job_valid,
   input  job_type          job,
   input  logic             rsp_stall,
   output logic             adv,
   output logic             rsp_valid,
   output logic [PIX_W-1:0] rsp_shade,
   output tag_type          rsp_tag
);

   // input and gradient stages
   logic             v0_ff, v1_ff, v2_ff;
   job_type          job0_ff;
   logic [8:0]       dx1_ff, dy1_ff;
   logic [PIX_W-1:0] c1_ff, c2_ff;
   tag_type          t1_ff, t2_ff;
   logic [17:0]      s2_ff;
   logic [12:0]      num2_ff;

   logic [7:0]         adx, ady;
   logic signed [14:0] dxs, dys, num_s;

   // square root stages
   logic             sv_ff    [0:SQRT_STEPS-1];
   logic [26:0]      srem_ff  [0:SQRT_STEPS-1];
   logic [24:0]      sroot_ff [0:SQRT_STEPS-1];
   logic [17:0]      sx_ff    [0:SQRT_STEPS-1];
   logic [32:0]      sprod_ff [0:SQRT_STEPS-1];
   logic [PIX_W-1:0] sc_ff    [0:SQRT_STEPS-1];
   tag_type          st_ff    [0:SQRT_STEPS-1];

   // division stages
   logic             dv_ff   [0:DIV_STEPS-1];
   logic [24:0]      drem_ff [0:DIV_STEPS-1];
   logic [24:0]      dd_ff   [0:DIV_STEPS-1];
   logic [17:0]      dbits_ff[0:DIV_STEPS-1];
   logic [17:0]      dq_ff   [0:DIV_STEPS-1];
   logic [PIX_W-1:0] dc_ff   [0:DIV_STEPS-1];
   tag_type          dt_ff   [0:DIV_STEPS-1];

   // tail
   logic             lv_ff, av_ff, rsp_valid_ff;
   logic [28:0]      lprod_ff;
   logic [PIX_W-1:0] lc_ff;
   tag_type          lt_ff, at_ff, rsp_tag_ff;
   logic [12:0]      ax_ff;
   logic [PIX_W-1:0] rsp_shade_ff;

   logic [16:0] lam;
   logic [13:0] acc_sum;
   logic [12:0] ambient;
   logic [26:0] div20;

   assign adv       = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_shade = rsp_shade_ff;
   assign rsp_tag   = rsp_tag_ff;

   // gradient
   always_comb begin
      adx   = dx1_ff[8] ? 8'(-dx1_ff) : dx1_ff[7:0];
      ady   = dy1_ff[8] ? 8'(-dy1_ff) : dy1_ff[7:0];
      dxs   = {{6{dx1_ff[8]}}, dx1_ff};
      dys   = {{6{dy1_ff[8]}}, dy1_ff};
      num_s = dxs * 15'sd11 + dys * 15'sd9 + $signed(NUM_BIAS);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (adv) begin
         v0_ff <= job_valid;
         v1_ff <= v0_ff;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         job0_ff <= job;
         dx1_ff  <= {1'b0, job0_ff.right} - {1'b0, job0_ff.left};
         dy1_ff  <= {1'b0, job0_ff.down} - {1'b0, job0_ff.up};
         c1_ff   <= job0_ff.center;
         t1_ff   <= job0_ff.tag;
         s2_ff   <= 18'(adx * adx) + 18'(ady * ady) + Z_SQUARED;
         num2_ff <= (num_s > 15'sd0) ? 13'(num_s) : '0;
         c2_ff   <= c1_ff;
         t2_ff   <= t1_ff;
      end
   end

   // square root of s * 2^32, one root bit per stage
   for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_sqrt
      logic             v_src;
      logic [26:0]      rem_src;
      logic [24:0]      root_src;
      logic [17:0]      x_src;
      logic [32:0]      prod_src;
      logic [PIX_W-1:0] c_src;
      tag_type          t_src;
      sqrt_step_type    stp;

      if (i == 0) begin : g_first
         always_comb begin
            v_src    = v2_ff;
            rem_src  = '0;
            root_src = '0;
            x_src    = s2_ff;
            prod_src = 33'(num2_ff) * 33'(LIGHT_SCALE);
            c_src    = c2_ff;
            t_src    = t2_ff;
         end
      end else begin : g_next
         always_comb begin
            v_src    = sv_ff[i-1];
            rem_src  = srem_ff[i-1];
            root_src = sroot_ff[i-1];
            x_src    = sx_ff[i-1];
            prod_src = sprod_ff[i-1];
            c_src    = sc_ff[i-1];
            t_src    = st_ff[i-1];
         end
      end

      assign stp = sqrt_step(rem_src, root_src, x_src[17:16]);

      always_ff @(posedge clock) begin
         if (reset) begin
            sv_ff[i] <= 1'b0;
         end else if (adv) begin
            sv_ff[i] <= v_src;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            srem_ff[i]  <= stp.rem;
            sroot_ff[i] <= stp.root;
            sx_ff[i]    <= {x_src[15:0], 2'b00};
            sprod_ff[i] <= prod_src;
            sc_ff[i]    <= c_src;
            st_ff[i]    <= t_src;
         end
      end
   end

   // (prod << 8) / root, one quotient bit per stage
   for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
      logic             v_src;
      logic [24:0]      rem_src;
      logic [24:0]      d_src;
      logic [17:0]      bits_src;
      logic [17:0]      q_src;
      logic [PIX_W-1:0] c_src;
      tag_type          t_src;
      div_step_type     stp;

      if (j == 0) begin : g_first
         always_comb begin
            v_src    = sv_ff[SQRT_STEPS-1];
            rem_src  = 25'(sprod_ff[SQRT_STEPS-1][32:10]);
            d_src    = sroot_ff[SQRT_STEPS-1];
            bits_src = {sprod_ff[SQRT_STEPS-1][9:0], 8'h00};
            q_src    = '0;
            c_src    = sc_ff[SQRT_STEPS-1];
            t_src    = st_ff[SQRT_STEPS-1];
         end
      end else begin : g_next
         always_comb begin
            v_src    = dv_ff[j-1];
            rem_src  = drem_ff[j-1];
            d_src    = dd_ff[j-1];
            bits_src = dbits_ff[j-1];
            q_src    = dq_ff[j-1];
            c_src    = dc_ff[j-1];
            t_src    = dt_ff[j-1];
         end
      end

      assign stp = div_step(rem_src, d_src, bits_src[17]);

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_ff[j] <= 1'b0;
         end else if (adv) begin
            dv_ff[j] <= v_src;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            drem_ff[j]  <= stp.rem;
            dd_ff[j]    <= d_src;
            dbits_ff[j] <= {bits_src[16:0], 1'b0};
            dq_ff[j]    <= {q_src[16:0], stp.qbit};
            dc_ff[j]    <= c_src;
            dt_ff[j]    <= t_src;
         end
      end
   end

   // Lambert capped at one, then ambient + diffuse, capped, divided by 20
   always_comb begin
      lam     = (dq_ff[DIV_STEPS-1] > LAMBERT_ONE) ? 17'(LAMBERT_ONE)
                                                   : 17'(dq_ff[DIV_STEPS-1]);
      ambient = AMBIENT_K + HEIGHT_K * 13'(lc_ff);
      acc_sum = 14'(ambient) + 14'(lprod_ff[28:16]);
      div20   = 27'(ax_ff[12:2]) * 27'(DIV5_MAGIC);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lv_ff        <= 1'b0;
         av_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         lv_ff        <= dv_ff[DIV_STEPS-1];
         av_ff        <= lv_ff;
         rsp_valid_ff <= av_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         lprod_ff     <= 29'(lam) * 29'(DIFFUSE_K);
         lc_ff        <= dc_ff[DIV_STEPS-1];
         lt_ff        <= dt_ff[DIV_STEPS-1];
         ax_ff        <= (acc_sum > 14'(ACC_CAP)) ? ACC_CAP : 13'(acc_sum);
         at_ff        <= lt_ff;
         rsp_shade_ff <= PIX_W'(div20[26:18]);
         rsp_tag_ff   <= at_ff;
      end
   end

endmodule

// ===== sim/tb_hillshade_pixel_stream.sv =====
// ----------------------------------------------------------------------------
// tb_hillshade_pixel_stream
// Self-checking bench for the hillshade pixel stream. Height words go in
// through a short directed table, a long frame with no idling, then random
// frames of many sizes, with random input gaps and output stalls. Every shade word is
// predicted here from the accepted heights and the current frame sizes, and
// each word leaving the block is checked against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_hillshade_pixel_stream;
   import hps_pkg::*;

   localparam logic [CSR_IDX_W-1:0] REG_UNUSED = 2'd3;   // no register here
   localparam int DRAIN_CYCLES = 80;                      // > pipeline latency
   localparam int RANDOM_ITEMS = 120;

   typedef struct {
      logic [PIX_W-1:0] shade;
      logic [COL_W-1:0] col;
      logic [ROW_W-1:0] row;
      logic             last;
      logic             eof;
   } shade_word_type;

   typedef struct {
      bit                    is_csr;
      logic [CSR_IDX_W-1:0]  idx;
      logic [CSR_DATA_W-1:0] data;
      logic [PIX_W-1:0]      height;
      int                    want_shade;   // -1: take the predicted shade
   } step_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic [PIX_W-1:0]      req_height_sample;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic [PIX_W-1:0]      rsp_shade;
   logic [COL_W-1:0]      rsp_column;
   logic [ROW_W-1:0]      rsp_row;
   logic                  rsp_last_of_run;
   logic                  rsp_end_of_frame;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   // predictor state
   logic [PIX_W-1:0] upper_rows [1024];
   logic [PIX_W-1:0] recent_rows [1024];
   int unsigned      width_reg = 1024;
   int unsigned      height_reg = 1024;
   int unsigned      col_pos = 0;
   int unsigned      row_pos = 0;
   logic [15:0]      prev_pair = '0;

   shade_word_type pending_shades [$];
   int             errors = 0;
   bit             quiet = 1'b0;
   bit             hold_req = 1'b0;
   int             hold_left = 0;
   int             random_count = 0;

   hillshade_pixel_stream dut (.*);

   initial begin
      forever #6 clock = ~clock;
   end

   initial begin
      #(12 * 400000);
      $display("tb_hillshade_pixel_stream: errors");
      $finish;
   end

   function automatic longint unsigned isqrt(input longint unsigned x);
      longint unsigned root, trial;
      root = 0;
      for (int b = 31; b >= 0; b--) begin
         trial = root | (64'd1 << b);
         if (trial * trial <= x) root = trial;
      end
      return root;
   endfunction

   function automatic logic [PIX_W-1:0] lambert_shade(input int c, input int l, input int r,
                                                       input int u, input int d);
      int              dx, dy, num;
      longint unsigned lam, acc, den;
      dx  = r - l;
      dy  = d - u;
      num = 11 * dx + 9 * dy + 1792;
      lam = 0;
      if (num > 0) begin
         den = isqrt(longint'(dx * dx + dy * dy + 16384) << 32);
         lam = ((longint'(num) * 840966) << 8) / den;
         if (lam > 65536) lam = 65536;
      end
      acc = (longint'(1785 + 9 * c) << 16) + 2805 * lam;
      if (acc > (64'd5100 << 16)) acc = 64'd5100 << 16;
      acc = acc / (64'd20 << 16);
      return (acc > 255) ? 8'd255 : acc[7:0];
   endfunction

   function automatic shade_word_type make_word(input logic [PIX_W-1:0] s,
                                                input int unsigned c,
                                                input int unsigned r, input logic eof);
      shade_word_type w;
      w.shade = s;
      w.col   = c[COL_W-1:0];
      w.row   = r[ROW_W-1:0];
      w.last  = 1'b0;
      w.eof   = eof;
      return w;
   endfunction

   // works out the shade words caused by one accepted height
   task automatic predict_height(input logic [PIX_W-1:0] p, input int want_shade);
      int unsigned      w, h, c, r;
      int               n;
      logic [PIX_W-1:0] mid_c, mid_l, mid_r, up, prev_in, left;
      shade_word_type   outs [3];
      w = (width_reg > 1024) ? 1024 : width_reg;
      h = (height_reg > 4096) ? 4096 : height_reg;
      if (w < 2 || h < 2) return;
      if (col_pos >= w || row_pos >= h) begin
         col_pos = 0;
         row_pos = 0;
      end
      c = col_pos;
      r = row_pos;
      n = 0;
      mid_c = '0;
      if (r >= 1) begin
         mid_c = recent_rows[c];
         mid_r = (c + 1 < w) ? recent_rows[c+1] : mid_c;
         mid_l = (c > 0) ? prev_pair[7:0] : mid_c;
         up    = (r >= 2) ? upper_rows[c] : mid_c;
         outs[n++] = make_word(lambert_shade(mid_c, mid_l, mid_r, up, p), c, r - 1, 1'b0);
      end
      if (r == h - 1) begin
         prev_in = prev_pair[15:8];
         if (c >= 1) begin
            left = (c >= 2) ? recent_rows[c-2] : prev_in;
            outs[n++] = make_word(lambert_shade(prev_in, left, p, prev_pair[7:0], prev_in),
                                  c - 1, r, 1'b0);
         end
         if (c == w - 1)
            outs[n++] = make_word(lambert_shade(p, prev_in, p, mid_c, p), c, r, 1'b1);
      end
      if (n > 0) outs[n-1].last = 1'b1;
      for (int k = 0; k < n; k++) begin
         if (want_shade >= 0) outs[k].shade = want_shade[7:0];
         pending_shades.push_back(outs[k]);
      end
      prev_pair      = {p, mid_c};
      upper_rows[c]  = mid_c;
      recent_rows[c] = p;
      if (c + 1 >= w) begin
         col_pos = 0;
         row_pos = (r + 1 >= h) ? 0 : r + 1;
      end else begin
         col_pos = c + 1;
      end
   endtask

   // block must be empty before a register write
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      req_valid <= 1'b0;
      wait (pending_shades.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == REG_FRAME_WIDTH) width_reg = data[CFG_WID_W-1:0];
      else if (idx == REG_FRAME_HEIGHT) height_reg = data[CFG_HGT_W-1:0];
      if (idx == REG_FRAME_WIDTH || idx == REG_FRAME_HEIGHT) begin
         col_pos   = 0;
         row_pos   = 0;
         prev_pair = '0;
      end
   endtask

   task automatic send_height(input logic [PIX_W-1:0] p, input int want_shade);
      while (!quiet && $urandom_range(99) < 22) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_height_sample <= p;
      do @(posedge clock); while (req_stall);
      predict_height(p, want_shade);
   endtask

   function automatic logic [PIX_W-1:0] rand_height();
      if ($urandom_range(3) == 0) return $urandom_range(1) ? 8'd255 : 8'd0;
      return $urandom_range(255);
   endfunction

   // receiver: random stalls, plus one long hold-off on request
   always @(posedge clock) begin
      if (hold_req && hold_left == 0) begin
         hold_req  = 1'b0;
         hold_left = 300;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= !quiet && ($urandom_range(99) < 22);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_shades.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected shade word: col %0d row %0d",
                                       rsp_column, rsp_row);
         end else begin
            shade_word_type e;
            e = pending_shades.pop_front();
            if (rsp_shade !== e.shade || rsp_column !== e.col || rsp_row !== e.row ||
                rsp_last_of_run !== e.last || rsp_end_of_frame !== e.eof) begin
               errors++;
               if (errors <= 10)
                  $display("mismatch: exp %0d c%0d r%0d l%0b e%0b got %0d c%0d r%0d l%0b e%0b",
                           e.shade, e.col, e.row, e.last, e.eof, rsp_shade, rsp_column,
                           rsp_row, rsp_last_of_run, rsp_end_of_frame);
            end
         end
      end
   end

   initial begin
      step_type    steps [$];
      int unsigned w, h, n;
      reset             <= 1'b1;
      req_valid         <= 1'b0;
      req_height_sample <= '0;
      csr_valid         <= 1'b0;
      csr_index         <= REG_FRAME_WIDTH;
      csr_data          <= '0;
      rsp_stall         <= 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed part; want_shade typed only where obvious
      steps = '{
         '{1, REG_FRAME_WIDTH,  13'd0,    8'd0,   -1},   // no output below width two
         '{0, REG_FRAME_WIDTH,  13'd0,    8'd0,   -1},
         '{0, REG_FRAME_WIDTH,  13'd0,    8'd255, -1},
         '{1, REG_FRAME_WIDTH,  13'd2047, 8'd0,   -1},   // oversize acts as max
         '{1, REG_FRAME_HEIGHT, 13'd8191, 8'd0,   -1},
         '{0, REG_FRAME_WIDTH,  13'd0,    8'h55,  -1},
         '{0, REG_FRAME_WIDTH,  13'd0,    8'hAA,  -1},
         '{1, REG_UNUSED,       13'h1FFF, 8'd0,   -1},   // ignored index
         '{1, REG_FRAME_WIDTH,  13'd2,    8'd0,   -1},
         '{1, REG_FRAME_HEIGHT, 13'd2,    8'd0,   -1},
         '{0, REG_FRAME_WIDTH,  13'd0,    8'd0,   -1},
         '{0, REG_FRAME_WIDTH,  13'd0,    8'd255, -1},
         '{0, REG_FRAME_WIDTH,  13'd0,    8'd255, -1},
         '{0, REG_FRAME_WIDTH,  13'd0,    8'd0,   -1},
         '{1, REG_FRAME_HEIGHT, 13'd0,    8'd0,   -1},   // height below two
         '{0, REG_FRAME_WIDTH,  13'd0,    8'd7,   -1},
         '{1, REG_FRAME_WIDTH,  13'd3,    8'd0,   -1},
         '{1, REG_FRAME_HEIGHT, 13'd2,    8'd0,   -1},
         '{0, REG_FRAME_WIDTH,  13'd0,    8'd255, 255},  // flat top saturates
         '{0, REG_FRAME_WIDTH,  13'd0,    8'd255, 255},
         '{0, REG_FRAME_WIDTH,  13'd0,    8'd255, 255},
         '{0, REG_FRAME_WIDTH,  13'd0,    8'd255, 255},
         '{0, REG_FRAME_WIDTH,  13'd0,    8'd255, 255},
         '{0, REG_FRAME_WIDTH,  13'd0,    8'd255, 255}
      };
      foreach (steps[i]) begin
         if (steps[i].is_csr) write_reg(steps[i].idx, steps[i].data);
         else send_height(steps[i].height, steps[i].want_shade);
      end
      req_valid <= 1'b0;

      // long frame, no idling at all
      quiet = 1'b1;
      write_reg(REG_FRAME_WIDTH, 13'd24);
      write_reg(REG_FRAME_HEIGHT, 13'd3);
      for (int k = 0; k < 72; k++) send_height(rand_height(), -1);
      req_valid <= 1'b0;
      quiet = 1'b0;

      while (random_count < RANDOM_ITEMS) begin
         if ($urandom_range(9) < 8) begin
            w = $urandom_range(2, 8);
            h = $urandom_range(2, 5);
         end else begin
            w = $urandom_range(9, 40);
            h = $urandom_range(2, 4);
         end
         write_reg(REG_FRAME_WIDTH, w[CSR_DATA_W-1:0]);
         write_reg(REG_FRAME_HEIGHT, h[CSR_DATA_W-1:0]);
         n = w * h;
         if ($urandom_range(4) == 0) n = $urandom_range(1, n);   // cut-off frame
         if (n > RANDOM_ITEMS - random_count) n = RANDOM_ITEMS - random_count;
         if (random_count == 0) hold_req = 1'b1;                  // fill the queue
         for (int k = 0; k < n; k++) begin
            send_height(rand_height(), -1);
            random_count++;
         end
         req_valid <= 1'b0;
      end

      wait (pending_shades.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0) begin
         $display("tb_hillshade_pixel_stream: clean");
      end else begin
         $display("tb_hillshade_pixel_stream: errors");
      end
      $finish;
   end

endmodule
